// ===== sv/ivpc_pkg.sv =====
`timescale 1ns / 1ps
// Package: payload types and constants for the pixel combine core.
package ivpc_pkg;

   localparam int FracBitsDefault = 16;
   localparam int MagBits = 65;
   localparam int DivBits = 33;

   typedef struct packed {
      logic signed [31:0] value_a;
      logic [31:0]        weight_a;
      logic [31:0]        hits_a;
      logic [31:0]        variance_a;
      logic               bad_a;
      logic signed [31:0] value_b;
      logic [31:0]        weight_b;
      logic [31:0]        hits_b;
      logic [31:0]        variance_b;
      logic               bad_b;
      logic               last_pixel;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic [31:0]        weight_out;
      logic [31:0]        hits_out;
      logic [31:0]        variance_out;
      logic               bad_out;
      logic               error_out;
      logic               last_out;
   } rsp_type;

endpackage

// ===== sv/ivpc_req_if.sv =====
`timescale 1ns / 1ps
// Interface: valid/ready channel carrying one pixel pair per beat.
interface ivpc_req_if;
   logic               valid;
   logic               ready;
   ivpc_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ivpc_rsp_if.sv =====
`timescale 1ns / 1ps
// Interface: valid/ready channel carrying one combined pixel per beat.
interface ivpc_rsp_if;
   logic               valid;
   logic               ready;
   ivpc_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/inverse_variance_pixel_combine_core.sv =====
`timescale 1ns / 1ps
// Top level: pipelined inverse-variance combine of two map pixels.
//
//  channel  | dir | payload
//  req      | in  | two pixels (value, weight, hits, variance, bad) + last_pixel
//  rsp      | out | combined pixel, error_out, last_out
//
// One pixel pair per cycle while the output is not stalled; data passes through the
// product and sum stages, the 33-stage restoring divider (two quotients, one
// bit each per stage) and the output stage. The sticky error is resolved at the
// output stage in pixel order. Reset clears valid bits and the error flag.
// The whole pipe advances only when the output register is empty or taken.
module inverse_variance_pixel_combine_core #(
   parameter int FRAC_BITS = ivpc_pkg::FracBitsDefault
) (
   input logic clock,
   input logic reset,
   ivpc_req_if.sink   req,
   ivpc_rsp_if.source rsp
);
   import ivpc_pkg::*;

   localparam int Stages = DivBits;

   typedef struct packed {
      req_type              px;
      logic                 zero_w;
      logic                 neg;
      logic [MagBits-1:0]   mrem;
      logic [DivBits-1:0]   mquo;
      logic [MagBits-1:0]   vrem;
      logic [DivBits-1:0]   vquo;
      logic [DivBits-1:0]   wsum;
   } work_type;

   logic     adv;
   logic     v0_ff;
   req_type  px0_ff;
   logic [63:0] p_ff, q_ff;
   logic     v_ff [Stages+1];
   work_type w_ff [Stages+1];
   work_type w_in [Stages+1];
   logic     ov_ff;
   rsp_type  od_ff;
   logic     halt_ff;

   assign adv = !ov_ff || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = ov_ff;
   assign rsp.data = od_ff;

   function automatic logic [31:0] mag_of(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // Stage 0: register inputs, form products.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req.valid;
      end
      if (adv) begin
         px0_ff <= req.data;
         p_ff <= 64'(req.data.weight_a) * 64'(mag_of(req.data.value_a));
         q_ff <= 64'(req.data.weight_b) * 64'(mag_of(req.data.value_b));
      end
   end

   // Stage 1: signed sum of products, weight sum.
   always_comb begin
      logic na, nb;
      logic [MagBits-1:0] pp, qq;
      na = px0_ff.value_a[31];
      nb = px0_ff.value_b[31];
      pp = MagBits'(p_ff);
      qq = MagBits'(q_ff);
      w_in[0] = '0;
      w_in[0].px = px0_ff;
      w_in[0].wsum = DivBits'(px0_ff.weight_a) + DivBits'(px0_ff.weight_b);
      w_in[0].zero_w = (w_in[0].wsum == '0);
      if (na == nb) begin
         w_in[0].mrem = pp + qq;
         w_in[0].neg = na;
      end else if ((na ? pp : qq) > (na ? qq : pp)) begin
         w_in[0].mrem = na ? pp - qq : qq - pp;
         w_in[0].neg = 1'b1;
      end else begin
         w_in[0].mrem = na ? qq - pp : pp - qq;
         w_in[0].neg = 1'b0;
      end
      w_in[0].vrem = MagBits'(1) << (2 * FRAC_BITS);
   end

   // Divider stages: one quotient bit of each division per stage, MSB first.
   for (genvar s = 1; s <= Stages; s++) begin : g_div
      localparam int Bit = Stages - s;
      always_comb begin
         logic [MagBits+DivBits-1:0] dsh;
         w_in[s] = w_ff[s-1];
         dsh = (MagBits+DivBits)'(w_ff[s-1].wsum) << Bit;
         if ((MagBits+DivBits)'(w_ff[s-1].mrem) >= dsh) begin
            w_in[s].mrem = w_ff[s-1].mrem - MagBits'(dsh);
            w_in[s].mquo[Bit] = 1'b1;
         end
         if ((MagBits+DivBits)'(w_ff[s-1].vrem) >= dsh) begin
            w_in[s].vrem = w_ff[s-1].vrem - MagBits'(dsh);
            w_in[s].vquo[Bit] = 1'b1;
         end
      end
   end

   for (genvar s = 0; s <= Stages; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= (s == 0) ? v0_ff : v_ff[s-((s == 0) ? 0 : 1)];
         end
         if (adv) begin
            w_ff[s] <= w_in[s];
         end
      end
   end

   // Output stage: pick pass-on or combined result, resolve the sticky error.
   always_ff @(posedge clock) begin
      work_type t;
      logic h;
      rsp_type o;
      t = w_ff[Stages];
      h = halt_ff;
      o.value_out = t.px.value_a;
      o.weight_out = t.px.weight_a;
      o.hits_out = t.px.hits_a;
      o.variance_out = t.px.variance_a;
      o.bad_out = t.px.bad_a;
      if (!halt_ff && t.px.bad_a) begin
         o.value_out = t.px.value_b;
         o.weight_out = t.px.weight_b;
         o.hits_out = t.px.hits_b;
         o.variance_out = t.px.variance_b;
         o.bad_out = t.px.bad_b;
      end else if (!halt_ff && !t.px.bad_b) begin
         if (t.zero_w) begin
            h = 1'b1;
         end else begin
            o.value_out = t.neg ? (~t.mquo[31:0] + 32'd1) : t.mquo[31:0];
            o.weight_out = t.wsum[32] ? '1 : t.wsum[31:0];
            o.hits_out = t.px.hits_a + t.px.hits_b;
            o.variance_out = t.vquo[32] ? '1 : t.vquo[31:0];
            o.bad_out = 1'b0;
         end
      end
      o.error_out = h;
      o.last_out = t.px.last_pixel;
      if (reset) begin
         ov_ff <= 1'b0;
         halt_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v_ff[Stages];
         if (v_ff[Stages]) begin
            halt_ff <= h && !t.px.last_pixel;
         end
      end
      if (adv) begin
         od_ff <= o;
      end
   end

endmodule

// ===== verif/tb_inverse_variance_pixel_combine_core.sv =====
`timescale 1ns / 1ps
// Testbench: random and directed pixel pairs checked against a behavioural combine model.
module tb_inverse_variance_pixel_combine_core;
   import ivpc_pkg::*;

   localparam int FracBits = 16;
   localparam int PipeDepth = 2 + DivBits + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ivpc_req_if req_ch ();
   ivpc_rsp_if rsp_ch ();

   inverse_variance_pixel_combine_core #(.FRAC_BITS(FracBits)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   req_type pixel_queue[$];
   rsp_type combined_queue[$];
   bit      halted_model;
   int      mismatch_count;
   int      beats_in;
   int      beats_out;
   int      send_idle_pct;
   int      recv_idle_pct;
   bit      recv_hold;
   bit      stim_done;
   int      hold_cycles;
   int      combined_seen;
   int      errors_seen;

   // Weighted mean of two signed values, exact and truncated toward zero.
   function automatic logic [31:0] mean_of(logic signed [31:0] va, logic [31:0] wa,
                                           logic signed [31:0] vb, logic [31:0] wb,
                                           logic [32:0] wsum);
      logic signed [66:0] num;
      logic [66:0]        mag;
      logic [66:0]        quo;
      num = $signed({35'd0, wa}) * $signed({{35{va[31]}}, va})
          + $signed({35'd0, wb}) * $signed({{35{vb[31]}}, vb});
      mag = num[66] ? -num : num;
      quo = mag / {34'd0, wsum};
      return num[66] ? -quo[31:0] : quo[31:0];
   endfunction

   function automatic rsp_type combine_pixel(req_type px);
      rsp_type     r;
      logic [32:0] wsum;
      logic [64:0] var_q;
      r = '0;
      wsum = {1'b0, px.weight_a} + {1'b0, px.weight_b};
      if (!halted_model && px.bad_a) begin
         r.value_out = px.value_b;
         r.weight_out = px.weight_b;
         r.hits_out = px.hits_b;
         r.variance_out = px.variance_b;
         r.bad_out = px.bad_b;
      end else if (halted_model || px.bad_b || wsum == 0) begin
         if (!halted_model && !px.bad_b) halted_model = 1'b1;
         r.value_out = px.value_a;
         r.weight_out = px.weight_a;
         r.hits_out = px.hits_a;
         r.variance_out = px.variance_a;
         r.bad_out = px.bad_a;
      end else begin
         var_q = (65'd1 << (2 * FracBits)) / {32'd0, wsum};
         r.value_out = mean_of(px.value_a, px.weight_a, px.value_b, px.weight_b, wsum);
         r.weight_out = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
         r.hits_out = px.hits_a + px.hits_b;
         r.variance_out = (var_q > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : var_q[31:0];
         r.bad_out = 1'b0;
         combined_seen++;
      end
      r.error_out = halted_model;
      if (r.error_out) errors_seen++;
      r.last_out = px.last_pixel;
      if (px.last_pixel) halted_model = 1'b0;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.value_a = pick_word();
      px.weight_a = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word();
      px.hits_a = pick_word();
      px.variance_a = pick_word();
      px.bad_a = ($urandom_range(0, 4) == 0);
      px.value_b = pick_word();
      px.weight_b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word();
      px.hits_b = pick_word();
      px.variance_b = pick_word();
      px.bad_b = ($urandom_range(0, 4) == 0);
      px.last_pixel = ($urandom_range(0, 19) == 0);
      return px;
   endfunction

   // Driver: offer the head of the queue, advance on each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            combined_queue.push_back(combine_pixel(req_ch.data));
            beats_in++;
         end
         if ((!req_ch.valid || req_ch.ready) && pixel_queue.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pixel_queue.pop_front();
         end else if (!req_ch.valid || req_ch.ready) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_out++;
            if (combined_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat %h", rsp_ch.data);
            end else begin
               want = combined_queue.pop_front();
               if (rsp_ch.data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch beat %0d: want v=%h w=%h h=%h var=%h b=%b e=%b l=%b",
                              beats_out, want.value_out, want.weight_out, want.hits_out,
                              want.variance_out, want.bad_out, want.error_out,
                              want.last_out);
                     $display("   got v=%h w=%h h=%h var=%h b=%b e=%b l=%b",
                              rsp_ch.data.value_out,
                              rsp_ch.data.weight_out, rsp_ch.data.hits_out,
                              rsp_ch.data.variance_out, rsp_ch.data.bad_out,
                              rsp_ch.data.error_out, rsp_ch.data.last_out);
                  end
               end
            end
         end
         rsp_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off, counted here, so the pipe backs up into the input.
   always @(posedge clock) begin
      if (reset) begin
         recv_hold <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         if (hold_cycles == 1) recv_hold <= 1'b0;
      end else if (!recv_hold && beats_in == 300) begin
         recv_hold <= 1'b1;
         hold_cycles <= 4 * PipeDepth;
      end
   end

   task automatic wait_drained();
      while (pixel_queue.size() > 0 || req_ch.valid || combined_queue.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_pixel(logic [31:0] va, logic [31:0] wa, bit ba,
                            logic [31:0] vb, logic [31:0] wb, bit bb, bit last);
      req_type px;
      px = random_pixel();
      px.value_a = va;
      px.weight_a = wa;
      px.bad_a = ba;
      px.value_b = vb;
      px.weight_b = wb;
      px.bad_b = bb;
      px.last_pixel = last;
      pixel_queue.push_back(px);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 48;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, each path through the select, the sticky error.
      add_pixel(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      add_pixel(32'h8000_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
      add_pixel(32'h8000_0000, 32'h0000_0001, 0, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0);
      add_pixel(32'h0001_0000, 32'h0000_0001, 0, 32'hFFFF_0000, 32'h0000_0000, 0, 0);
      add_pixel(32'h0001_0000, 32'h0001_0000, 0, 32'h0002_0000, 32'h0001_0000, 0, 0);
      add_pixel(32'h1234_5678, 32'h0000_0010, 1, 32'h8765_4321, 32'h0000_0020, 0, 0);
      add_pixel(32'h1234_5678, 32'h0000_0010, 1, 32'h8765_4321, 32'h0000_0020, 1, 0);
      add_pixel(32'h1234_5678, 32'h0000_0010, 0, 32'h8765_4321, 32'h0000_0020, 1, 0);
      add_pixel(32'h0000_0000, 32'h0000_0000, 0, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0);
      add_pixel(32'h0003_0000, 32'h0001_0000, 0, 32'h0004_0000, 32'h0001_0000, 0, 0);
      add_pixel(32'h0005_0000, 32'h0001_0000, 1, 32'h0006_0000, 32'h0001_0000, 0, 0);
      add_pixel(32'h0007_0000, 32'h0001_0000, 0, 32'h0008_0000, 32'h0001_0000, 1, 1);
      add_pixel(32'h0009_0000, 32'h0001_0000, 0, 32'h000A_0000, 32'h0001_0000, 0, 0);
      add_pixel(32'hFFFF_FFFF, 32'h8000_0000, 0, 32'h0000_0001, 32'h8000_0000, 0, 1);
      add_pixel(32'h0000_0000, 32'h0000_0000, 0, 32'h0000_0000, 32'h0000_0000, 0, 1);
      add_pixel(32'h0000_0001, 32'h0000_0001, 0, 32'h0000_0001, 32'h0000_0000, 0, 0);
      wait_drained();

      // Three random phases, each drained: slow receiver, slow sender, no idling.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 11 : 0;
         for (int i = 0; i < 400; i++) pixel_queue.push_back(random_pixel());
         wait_drained();
      end
      wait_drained();
      repeat (PipeDepth + 5) @(posedge clock);
      $display("covered %0d pixel pairs, %0d combined, %0d with error flagged",
               beats_in, combined_seen, errors_seen);
      if (mismatch_count == 0 && combined_queue.size() == 0) begin
         $display("inverse_variance_pixel_combine_core test passed");
      end else begin
         $display("inverse_variance_pixel_combine_core test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("inverse_variance_pixel_combine_core test failed");
      $finish;
   end

endmodule
